FILE: hw/rtl/grid_percolation_union_find_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the grid percolation union-find unit
// Clocked implication checks that switch off when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef GRID_PERCOLATION_UNION_FIND_UNIT_ASSERT_SVH
`define GRID_PERCOLATION_UNION_FIND_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define GPUF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define GPUF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GPUF_ASSERT_NOW(label, clk, rst, ante, cons)
`define GPUF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/gpuf_pkg.sv
// ----------------------------------------------------------------------------
// gpuf_pkg
// Widths, select codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package gpuf_pkg;

  localparam int AW    = 12;           // cell index width
  localparam int SZW   = 13;           // tree size width
  localparam int CNTW  = 16;           // open counter width
  localparam int GW    = 6;            // grid size / row / col width
  localparam int SIDEW = 7;            // side = N + 2
  localparam int CELLS = 1 << AW;
  localparam logic [GW-1:0] GRID_MAX = 6'd62;
  localparam logic [GW-1:0] GRID_RST = 6'd62;

  // memory address selects
  localparam logic [2:0] A_K   = 3'd0;
  localparam logic [2:0] A_ME  = 3'd1;
  localparam logic [2:0] A_NB  = 3'd2;
  localparam logic [2:0] A_CUR = 3'd3;
  localparam logic [2:0] A_RA  = 3'd4;
  localparam logic [2:0] A_RB  = 3'd5;

  // parent write data selects
  localparam logic [2:0] PD_SWEEP = 3'd0;
  localparam logic [2:0] PD_ME    = 3'd1;
  localparam logic [2:0] PD_ROOT  = 3'd2;
  localparam logic [2:0] PD_RA    = 3'd3;
  localparam logic [2:0] PD_RB    = 3'd4;

  // size write data selects
  localparam logic [1:0] SD_SWEEP = 2'd0;
  localparam logic [1:0] SD_ONE   = 2'd1;
  localparam logic [1:0] SD_SUM   = 2'd2;

  // walk pointer selects
  localparam logic [2:0] C_ME    = 3'd0;
  localparam logic [2:0] C_NB    = 3'd1;
  localparam logic [2:0] C_ZERO  = 3'd2;
  localparam logic [2:0] C_LAST  = 3'd3;
  localparam logic [2:0] C_PDATA = 3'd4;
  localparam logic [2:0] C_START = 3'd5;

  typedef struct packed {
    logic [2:0] p_addr_sel;
    logic [2:0] s_addr_sel;
    logic       wr_parent;
    logic [2:0] p_data_sel;
    logic       wr_size;
    logic [1:0] s_data_sel;
    logic       wr_open;
    logic       open_sweep;
    logic       sweep_clr;
    logic       sweep_inc;
    logic       load_item;
    logic       load_me;
    logic       count_inc;
    logic       nb_clr;
    logic       nb_load;
    logic       nb_inc;
    logic       cur_load;
    logic [2:0] cur_sel;
    logic       start_load;
    logic       root_load;
    logic       tgt_b;
    logic       size_a_load;
    logic       res_load;
    logic       res_zero;
  } cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic sweep_last;
    logic op_restart;
    logic in_range;
    logic odata;
    logic p_is_cur;
    logic cur_is_root;
    logic roots_eq;
    logic a_le_b;
    logic nb_last;
    logic out_full;
  } stat_t;

endpackage

FILE: hw/rtl/gpuf_datapath.sv
// ----------------------------------------------------------------------------
// gpuf_datapath
// Forest memories, walk registers, grid geometry and the result register.
// ----------------------------------------------------------------------------
module gpuf_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [5:0]             cfg_wdata,
  input  logic                   op,
  input  logic [5:0]             cell_row,
  input  logic [5:0]             cell_col,
  input  logic                   out_stall,
  input  gpuf_pkg::cmd_t         cmd,
  output gpuf_pkg::stat_t        stat,
  output logic                   out_valid,
  output logic                   percolates,
  output logic                   first_percolation,
  output logic [15:0]            open_count
);
  import gpuf_pkg::*;

  logic [AW-1:0]    parent_mem [CELLS];
  logic [SZW-1:0]   size_mem   [CELLS];
  logic             open_mem   [CELLS];

  logic [GW-1:0]    grid;
  logic [SIDEW-1:0] side;
  logic [AW:0]      sq;
  logic [AW-1:0]    last, side_a, hi;
  logic [AW-1:0]    k;
  logic             op_r;
  logic [GW-1:0]    row, col;
  logic [AW-1:0]    me, nb, cur, start, root_a, root_b;
  logic [1:0]       nb_idx;
  logic [SZW-1:0]   size_a;
  logic [CNTW-1:0]  count;
  logic             already;
  logic [AW-1:0]    pdata;
  logic [SZW-1:0]   sdata;
  logic             odata;
  logic [AW:0]      prod;
  logic [AW-1:0]    p_addr, s_addr, pwdata, nb_next, cur_src, tgt_root;
  logic [SZW-1:0]   swdata, sum;
  logic             owdata;

  // geometry
  assign side   = {1'b0, grid} + 7'd2;
  assign sq     = {6'b0, side} * {6'b0, side};
  assign last   = AW'(sq - 13'd1);
  assign side_a = {5'b0, side};
  assign hi     = last - side_a;
  assign prod   = {7'b0, row} * {6'b0, side};
  assign tgt_root = cmd.tgt_b ? root_b : root_a;
  assign sum    = size_a + sdata;

  // address and data muxes
  always_comb begin
    unique case (cmd.p_addr_sel)
      A_K:     p_addr = k;
      A_ME:    p_addr = me;
      A_NB:    p_addr = nb;
      A_CUR:   p_addr = cur;
      A_RA:    p_addr = root_a;
      A_RB:    p_addr = root_b;
      default: p_addr = k;
    endcase
    unique case (cmd.s_addr_sel)
      A_K:     s_addr = k;
      A_ME:    s_addr = me;
      A_NB:    s_addr = nb;
      A_CUR:   s_addr = cur;
      A_RA:    s_addr = root_a;
      A_RB:    s_addr = root_b;
      default: s_addr = k;
    endcase
    unique case (cmd.p_data_sel)
      PD_SWEEP: pwdata = (k < side_a) ? '0 : ((k > hi) ? last : k);
      PD_ME:    pwdata = me;
      PD_ROOT:  pwdata = tgt_root;
      PD_RA:    pwdata = root_a;
      PD_RB:    pwdata = root_b;
      default:  pwdata = k;
    endcase
    unique case (cmd.s_data_sel)
      SD_SWEEP: swdata = (k == '0 || k == last) ? {6'b0, side} : SZW'(1);
      SD_ONE:   swdata = SZW'(1);
      SD_SUM:   swdata = sum;
      default:  swdata = SZW'(1);
    endcase
    owdata = cmd.open_sweep ? ((k < side_a) || (k > hi)) : 1'b1;
    unique case (nb_idx)
      2'd0: nb_next = me - side_a;
      2'd1: nb_next = me + side_a;
      2'd2: nb_next = me - AW'(1);
      2'd3: nb_next = me + AW'(1);
      default: nb_next = me;
    endcase
    unique case (cmd.cur_sel)
      C_ME:    cur_src = me;
      C_NB:    cur_src = nb;
      C_ZERO:  cur_src = '0;
      C_LAST:  cur_src = last;
      C_PDATA: cur_src = pdata;
      C_START: cur_src = start;
      default: cur_src = start;
    endcase
  end

  // memories, read-before-write
  always_ff @(posedge clk) begin
    pdata <= parent_mem[p_addr];
    odata <= open_mem[p_addr];
    sdata <= size_mem[s_addr];
    if (cmd.wr_parent) parent_mem[p_addr] <= pwdata;
    if (cmd.wr_open)   open_mem[p_addr]   <= owdata;
    if (cmd.wr_size)   size_mem[s_addr]   <= swdata;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid      <= GRID_RST;
      k         <= '0;
      count     <= '0;
      already   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_wdata == '0)          grid <= GW'(1);
        else if (cfg_wdata > GRID_MAX) grid <= GRID_MAX;
        else                           grid <= cfg_wdata;
      end
      if (cfg_we || cmd.sweep_clr) begin
        k       <= '0;
        count   <= '0;
        already <= 1'b0;
      end else begin
        if (cmd.sweep_inc) k <= k + AW'(1);
        if (cmd.count_inc && count != '1) count <= count + CNTW'(1);
        if (cmd.res_load && !cmd.res_zero && stat.roots_eq) already <= 1'b1;
      end
      out_valid <= cmd.res_load | (out_valid & out_stall);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r <= op;
      row  <= cell_row;
      col  <= cell_col;
    end
    if (cmd.load_me)     me <= AW'(prod + {7'b0, col});
    if (cmd.nb_clr)      nb_idx <= '0;
    else if (cmd.nb_inc) nb_idx <= nb_idx + 2'd1;
    if (cmd.nb_load)     nb <= nb_next;
    if (cmd.cur_load)    cur <= cur_src;
    if (cmd.start_load)  start <= cur_src;
    if (cmd.root_load) begin
      if (cmd.tgt_b) root_b <= cur;
      else           root_a <= cur;
    end
    if (cmd.size_a_load) size_a <= sdata;
    if (cmd.res_load) begin
      percolates        <= !cmd.res_zero && stat.roots_eq;
      first_percolation <= !cmd.res_zero && stat.roots_eq && !already;
      open_count        <= count;
    end
  end

  // status
  assign stat.cfg_wr      = cfg_we;
  assign stat.sweep_last  = (k == last);
  assign stat.op_restart  = op_r;
  assign stat.in_range    = (row != '0) && (row <= grid) && (col != '0) && (col <= grid);
  assign stat.odata       = odata;
  assign stat.p_is_cur    = (pdata == cur);
  assign stat.cur_is_root = (cur == tgt_root);
  assign stat.roots_eq    = (root_a == root_b);
  assign stat.a_le_b      = (size_a <= sdata);
  assign stat.nb_last     = (nb_idx == 2'd3);
  assign stat.out_full    = out_valid & out_stall;

endmodule

FILE: hw/rtl/gpuf_ctrl.sv
// ----------------------------------------------------------------------------
// gpuf_ctrl
// Sequencer for clearing, cell open, neighbor unions and root finds.
// ----------------------------------------------------------------------------
module gpuf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  gpuf_pkg::stat_t stat,
  output gpuf_pkg::cmd_t  cmd,
  output logic            idle
);
  import gpuf_pkg::*;

  localparam logic [4:0] S_SWEEP = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DEC   = 5'd2;
  localparam logic [4:0] S_ORD   = 5'd3;
  localparam logic [4:0] S_OCHK  = 5'd4;
  localparam logic [4:0] S_NBA   = 5'd5;
  localparam logic [4:0] S_NRD   = 5'd6;
  localparam logic [4:0] S_NCHK  = 5'd7;
  localparam logic [4:0] S_FW    = 5'd8;
  localparam logic [4:0] S_FWC   = 5'd9;
  localparam logic [4:0] S_FC    = 5'd10;
  localparam logic [4:0] S_FCC   = 5'd11;
  localparam logic [4:0] S_URA   = 5'd12;
  localparam logic [4:0] S_URB   = 5'd13;
  localparam logic [4:0] S_UWR   = 5'd14;
  localparam logic [4:0] S_NEXT  = 5'd15;
  localparam logic [4:0] S_RES   = 5'd16;

  // which find is running
  localparam logic [1:0] F_A   = 2'd0;
  localparam logic [1:0] F_B   = 2'd1;
  localparam logic [1:0] F_TOP = 2'd2;
  localparam logic [1:0] F_BOT = 2'd3;

  logic [4:0] state, state_next;
  logic [1:0] fsel, fsel_next;
  logic       pend_res, pend_res_next;

  assign idle = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_SWEEP;
      fsel     <= F_A;
      pend_res <= 1'b0;
    end else begin
      state    <= state_next;
      fsel     <= fsel_next;
      pend_res <= pend_res_next;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.p_addr_sel = A_CUR;
    cmd.s_addr_sel = A_CUR;
    cmd.tgt_b     = fsel[0];
    state_next    = state;
    fsel_next     = fsel;
    pend_res_next = pend_res;
    unique case (state)
      S_SWEEP: begin
        cmd.p_addr_sel = A_K;
        cmd.s_addr_sel = A_K;
        cmd.wr_parent  = 1'b1;
        cmd.p_data_sel = PD_SWEEP;
        cmd.wr_size    = 1'b1;
        cmd.s_data_sel = SD_SWEEP;
        cmd.wr_open    = 1'b1;
        cmd.open_sweep = 1'b1;
        cmd.sweep_inc  = 1'b1;
        if (stat.sweep_last) state_next = pend_res ? S_RES : S_IDLE;
      end
      S_IDLE: begin
        cmd.load_item = in_valid;
        if (in_valid) state_next = S_DEC;
      end
      S_DEC: begin
        if (stat.op_restart) begin
          cmd.sweep_clr = 1'b1;
          pend_res_next = 1'b1;
          state_next    = S_SWEEP;
        end else begin
          cmd.load_me   = 1'b1;
          cmd.count_inc = 1'b1;
          state_next    = S_ORD;
        end
      end
      S_ORD: begin
        cmd.p_addr_sel = A_ME;
        state_next     = S_OCHK;
      end
      // open the cell if in range and still closed, else go to the top and bottom finds
      S_OCHK: begin
        cmd.p_addr_sel = A_ME;
        cmd.s_addr_sel = A_ME;
        if (stat.in_range && !stat.odata) begin
          cmd.wr_open    = 1'b1;
          cmd.wr_parent  = 1'b1;
          cmd.p_data_sel = PD_ME;
          cmd.wr_size    = 1'b1;
          cmd.s_data_sel = SD_ONE;
          cmd.nb_clr     = 1'b1;
          state_next     = S_NBA;
        end else begin
          cmd.cur_load   = 1'b1;
          cmd.start_load = 1'b1;
          cmd.cur_sel    = C_ZERO;
          fsel_next      = F_TOP;
          state_next     = S_FW;
        end
      end
      S_NBA: begin
        cmd.nb_load = 1'b1;
        state_next  = S_NRD;
      end
      S_NRD: begin
        cmd.p_addr_sel = A_NB;
        state_next     = S_NCHK;
      end
      S_NCHK: begin
        if (stat.odata) begin
          cmd.cur_load   = 1'b1;
          cmd.start_load = 1'b1;
          cmd.cur_sel    = C_ME;
          fsel_next      = F_A;
          state_next     = S_FW;
        end else begin
          state_next = S_NEXT;
        end
      end
      // root walk
      S_FW: state_next = S_FWC;
      S_FWC: begin
        cmd.cur_load = 1'b1;
        if (stat.p_is_cur) begin
          cmd.root_load = 1'b1;
          cmd.cur_sel   = C_START;
          state_next    = S_FC;
        end else begin
          cmd.cur_sel = C_PDATA;
          state_next  = S_FW;
        end
      end
      // path compression walk
      S_FC: state_next = S_FCC;
      S_FCC: begin
        if (!stat.cur_is_root) begin
          cmd.wr_parent  = 1'b1;
          cmd.p_data_sel = PD_ROOT;
          cmd.cur_load   = 1'b1;
          cmd.cur_sel    = C_PDATA;
          state_next     = S_FC;
        end else begin
          unique case (fsel)
            F_A: begin
              cmd.cur_load   = 1'b1;
              cmd.start_load = 1'b1;
              cmd.cur_sel    = C_NB;
              fsel_next      = F_B;
              state_next     = S_FW;
            end
            F_B: state_next = stat.roots_eq ? S_NEXT : S_URA;
            F_TOP: begin
              cmd.cur_load   = 1'b1;
              cmd.start_load = 1'b1;
              cmd.cur_sel    = C_LAST;
              fsel_next      = F_BOT;
              state_next     = S_FW;
            end
            F_BOT: state_next = S_RES;
            default: state_next = S_RES;
          endcase
        end
      end
      // weighted union
      S_URA: begin
        cmd.s_addr_sel = A_RA;
        state_next     = S_URB;
      end
      S_URB: begin
        cmd.s_addr_sel  = A_RB;
        cmd.size_a_load = 1'b1;
        state_next      = S_UWR;
      end
      S_UWR: begin
        cmd.wr_parent  = 1'b1;
        cmd.wr_size    = 1'b1;
        cmd.s_data_sel = SD_SUM;
        if (stat.a_le_b) begin
          cmd.p_addr_sel = A_RA;
          cmd.p_data_sel = PD_RB;
          cmd.s_addr_sel = A_RB;
        end else begin
          cmd.p_addr_sel = A_RB;
          cmd.p_data_sel = PD_RA;
          cmd.s_addr_sel = A_RA;
        end
        state_next = S_NEXT;
      end
      S_NEXT: begin
        if (stat.nb_last) begin
          cmd.cur_load   = 1'b1;
          cmd.start_load = 1'b1;
          cmd.cur_sel    = C_ZERO;
          fsel_next      = F_TOP;
          state_next     = S_FW;
        end else begin
          cmd.nb_inc = 1'b1;
          state_next = S_NBA;
        end
      end
      S_RES: begin
        if (!stat.out_full) begin
          cmd.res_load  = 1'b1;
          cmd.res_zero  = pend_res;
          pend_res_next = 1'b0;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // a register write rebuilds the frame from scratch
    if (stat.cfg_wr) begin
      state_next    = S_SWEEP;
      pend_res_next = 1'b0;
    end
  end

endmodule

FILE: hw/rtl/grid_percolation_union_find_unit.sv
// ----------------------------------------------------------------------------
// grid_percolation_union_find_unit
// Percolation tracker on an N by N grid using weighted union-find with
// path compression over on-chip forest memories.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_stall   | op, cell_row, cell_col
//   out     | output    | out_valid / out_stall | percolates, first_percolation,
//           |           |                       | open_count
//   cfg     | input     | cfg_we                | cfg_wdata (grid size)
//
// An open checks the cell and opens it if in range and still closed; for each
// open neighbor it then walks and compresses the paths to both roots and joins
// the roots by size unless they already match, and last it finds the roots of
// the top and bottom border rows. A reopened or out-of-range cell goes straight
// to those finds, one parent read at a time. Reset, a restart item and a register
// write sweep the forest, one cell a cycle; no item is taken during the sweep.
// A new item is taken while a result waits in the output register; the
// result stage holds if out_stall is high and the output register is full.
// ----------------------------------------------------------------------------
module grid_percolation_union_find_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [5:0]  cell_row,
  input  logic [5:0]  cell_col,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        percolates,
  output logic        first_percolation,
  output logic [15:0] open_count
);
  import gpuf_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  idle;

  assign in_stall = !idle;

  gpuf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .idle     (idle)
  );

  gpuf_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .op                (op),
    .cell_row          (cell_row),
    .cell_col          (cell_col),
    .out_stall         (out_stall),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .percolates        (percolates),
    .first_percolation (first_percolation),
    .open_count        (open_count)
  );

  // checks
`include "grid_percolation_union_find_unit_assert.svh"
  `GPUF_ASSERT_NOW(a_first_implies_perc, clk, rst, out_valid, (!first_percolation || percolates))
  `GPUF_ASSERT_NOW(a_no_perc_at_zero, clk, rst, (out_valid && open_count == 16'd0), !percolates)
  `GPUF_ASSERT_NEXT(a_busy_after_accept, clk, rst, (in_valid && !in_stall && !cfg_we), in_stall)

endmodule
